FILE: rtl/core/ufe_pkg.sv
// Shared types and codes of the union-find engine.
// No dependencies; union_find_engine_core and the testbench refer to it by scoped names.
package ufe_pkg;

    localparam int unsigned ELEM_W    = 10;
    localparam int unsigned ELEM_SPAN = 1 << ELEM_W;
    localparam int unsigned RANK_W    = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef enum logic [1:0] {
        REQ_MAKE  = 2'd0,
        REQ_UNION = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_FIND  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_EXISTS  = 2'd2
    } status_t;

endpackage

FILE: rtl/core/ufe_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ufe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ufe_find.sv
// Root walk with path compression over the parent RAM.
// Depends on nothing but the parent RAM ports that the top level hands in.
module ufe_find #(
    parameter int unsigned NUM_ELEMENTS = 1024,
    parameter int unsigned AW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] node,
    input  logic [AW-1:0] par_rdata,
    output logic [AW-1:0] par_raddr,
    output logic          par_we,
    output logic [AW-1:0] par_waddr,
    output logic [AW-1:0] par_wdata,
    output logic          done,
    output logic [AW-1:0] root
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_WALK = 3'b010,
        F_COMP = 3'b100
    } fstate_t;

    fstate_t       state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] root_reg, root_next;
    logic          par_in_range;

    assign par_in_range = (32'(par_rdata) < NUM_ELEMENTS);
    assign root         = root_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        root_next  = root_reg;
        par_raddr  = cur_reg;
        par_we     = 1'b0;
        par_waddr  = cur_reg;
        par_wdata  = root_reg;
        done       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                par_raddr = node;
                if (start)
                begin
                    cur_next   = node;
                    head_next  = node;
                    state_next = F_WALK;
                end
            end
            F_WALK:
            begin
                // stop at a self-pointing node or an out-of-range parent, then restart from the head
                if (par_rdata == cur_reg || !par_in_range)
                begin
                    root_next  = cur_reg;
                    cur_next   = head_reg;
                    par_raddr  = head_reg;
                    state_next = F_COMP;
                end
                else
                begin
                    cur_next  = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            F_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    done       = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    par_we = 1'b1;
                    if (!par_in_range)
                    begin
                        done       = 1'b1;
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        cur_next  = par_rdata;
                        par_raddr = par_rdata;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        head_reg <= head_next;
        root_reg <= root_next;
    end

endmodule

FILE: rtl/core/union_find_engine_core.sv
// Union-find engine: request sequencer, present/rank/parent RAMs, find unit.
// Depends on ufe_pkg, ufe_ram and ufe_find.
//
// Use: drive req_type, elem_a and elem_b and raise start; the word is taken
// at the clock edge where start is high and busy is low. busy stays high
// until the result word has been produced. The result (status, root_a,
// same_flag) is shown for exactly one cycle with done high; the receiver
// cannot stall it, so capture it on that cycle.
// Requests that need no root search (make set of a new element, make set
// out of range, find on a missing element) finish after the present-map
// checks in S_CHK_A and S_CHK_B; a union or query with neither element
// present also passes through S_RESOLVE. Each root search walks the parent
// RAM one link a cycle and then rewrites the path one link a cycle; linking
// two sets adds two rank RAM reads.
// Reset: the present map is swept to zero, one entry per cycle, over all
// min(NUM_ELEMENTS, 1024) entries after reset is released; busy is high
// throughout. Parent and rank entries are first written when an element is
// made and need no clearing.
module union_find_engine_core #(
    parameter int unsigned NUM_ELEMENTS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  logic [9:0] elem_a,
    input  logic [9:0] elem_b,
    output logic       busy,
    output logic       done,
    output logic [1:0] status,
    output logic [9:0] root_a,
    output logic       same_flag
);

    // Element fields are 10 bits, so slots past 1023 can never be named.
    localparam int unsigned DEPTH = (NUM_ELEMENTS < ufe_pkg::ELEM_SPAN) ?
                                    NUM_ELEMENTS : ufe_pkg::ELEM_SPAN;
    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_CHK_A   = 11'b000_0000_0100,
        S_CHK_B   = 11'b000_0000_1000,
        S_FIND_A  = 11'b000_0001_0000,
        S_WAIT_A  = 11'b000_0010_0000,
        S_FIND_B  = 11'b000_0100_0000,
        S_WAIT_B  = 11'b000_1000_0000,
        S_RESOLVE = 11'b001_0000_0000,
        S_RANK_A  = 11'b010_0000_0000,
        S_RANK_B  = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    ufe_pkg::req_t      req_reg, req_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      b_reg, b_next;
    logic               a_in_reg, a_in_next;
    logic               b_in_reg, b_in_next;
    logic               pa_reg, pa_next;
    logic               pb_reg, pb_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic [AW-1:0]      rb_reg, rb_next;
    ufe_pkg::rank_t     rank_a_reg, rank_a_next;

    logic               done_reg, done_next;
    ufe_pkg::status_t   status_reg, status_next;
    ufe_pkg::elem_t     root_reg, root_next;
    logic               same_reg, same_next;

    // present map port
    logic               pres_we;
    logic [AW-1:0]      pres_waddr;
    logic               pres_wdata;
    logic [AW-1:0]      pres_raddr;
    logic               pres_rdata;

    // rank table port
    logic               rank_we;
    logic [AW-1:0]      rank_waddr;
    ufe_pkg::rank_t     rank_wdata;
    logic [AW-1:0]      rank_raddr;
    ufe_pkg::rank_t     rank_rdata;

    // parent table port, shared between the sequencer and the find unit
    logic               seq_par_we;
    logic [AW-1:0]      seq_par_waddr;
    logic [AW-1:0]      seq_par_wdata;
    logic               par_we;
    logic [AW-1:0]      par_waddr;
    logic [AW-1:0]      par_wdata;
    logic [AW-1:0]      par_raddr;
    logic [AW-1:0]      par_rdata;

    // find unit handshake
    logic               f_start;
    logic [AW-1:0]      f_node;
    logic               f_we;
    logic [AW-1:0]      f_waddr;
    logic [AW-1:0]      f_wdata;
    logic               f_done;
    logic [AW-1:0]      f_root;

    logic               accept;
    logic               pb_now;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign root_a    = root_reg;
    assign same_flag = same_reg;
    assign pb_now    = b_in_reg && pres_rdata;

    assign f_start = (state_reg == S_FIND_A) || (state_reg == S_FIND_B);
    assign f_node  = (state_reg == S_FIND_B) ? b_reg : a_reg;

    // The find unit writes only while it compresses; the sequencer writes
    // only while the find unit is idle.
    assign par_we    = f_we || seq_par_we;
    assign par_waddr = f_we ? f_waddr : seq_par_waddr;
    assign par_wdata = f_we ? f_wdata : seq_par_wdata;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        req_next      = req_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        a_in_next     = a_in_reg;
        b_in_next     = b_in_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        rank_a_next   = rank_a_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        root_next     = root_reg;
        same_next     = same_reg;

        pres_we       = 1'b0;
        pres_waddr    = a_reg;
        pres_wdata    = 1'b1;
        pres_raddr    = a_reg;
        rank_we       = 1'b0;
        rank_waddr    = a_reg;
        rank_wdata    = '0;
        rank_raddr    = ra_reg;
        seq_par_we    = 1'b0;
        seq_par_waddr = a_reg;
        seq_par_wdata = a_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the present map to zero after reset
                pres_we       = 1'b1;
                pres_waddr    = clr_addr_reg;
                pres_wdata    = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                pres_raddr = elem_a[AW-1:0];
                if (accept)
                begin
                    req_next   = ufe_pkg::req_t'(req_type);
                    a_next     = elem_a[AW-1:0];
                    b_next     = elem_b[AW-1:0];
                    a_in_next  = (32'(elem_a) < NUM_ELEMENTS);
                    b_in_next  = (32'(elem_b) < NUM_ELEMENTS);
                    state_next = S_CHK_A;
                end
            end
            S_CHK_A:
            begin
                pa_next    = a_in_reg && pres_rdata;
                pres_raddr = b_reg;
                state_next = S_CHK_B;
            end
            S_CHK_B:
            begin
                pb_next = pb_now;
                unique case (req_reg)
                    ufe_pkg::REQ_MAKE:
                    begin
                        if (!a_in_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ufe_pkg::ST_MISSING;
                            root_next   = '0;
                            same_next   = 1'b0;
                            state_next  = S_IDLE;
                        end
                        else if (pa_reg)
                        begin
                            state_next = S_FIND_A;
                        end
                        else
                        begin
                            // new singleton: points at itself, rank zero
                            pres_we       = 1'b1;
                            rank_we       = 1'b1;
                            seq_par_we    = 1'b1;
                            done_next     = 1'b1;
                            status_next   = ufe_pkg::ST_DONE;
                            root_next     = ufe_pkg::elem_t'(a_reg);
                            same_next     = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                    ufe_pkg::REQ_FIND:
                    begin
                        if (pa_reg)
                        begin
                            state_next = S_FIND_A;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = ufe_pkg::ST_MISSING;
                            root_next   = '0;
                            same_next   = 1'b0;
                            state_next  = S_IDLE;
                        end
                    end
                    ufe_pkg::REQ_UNION, ufe_pkg::REQ_QUERY:
                    begin
                        // compress both paths whenever the element exists
                        if (pa_reg)
                        begin
                            state_next = S_FIND_A;
                        end
                        else if (pb_now)
                        begin
                            state_next = S_FIND_B;
                        end
                        else
                        begin
                            state_next = S_RESOLVE;
                        end
                    end
                endcase
            end
            S_FIND_A:
            begin
                state_next = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (f_done)
                begin
                    ra_next = f_root;
                    unique case (req_reg)
                        ufe_pkg::REQ_MAKE, ufe_pkg::REQ_FIND:
                        begin
                            done_next   = 1'b1;
                            status_next = (req_reg == ufe_pkg::REQ_MAKE) ?
                                          ufe_pkg::ST_EXISTS : ufe_pkg::ST_DONE;
                            root_next   = ufe_pkg::elem_t'(f_root);
                            same_next   = 1'b0;
                            state_next  = S_IDLE;
                        end
                        ufe_pkg::REQ_UNION, ufe_pkg::REQ_QUERY:
                        begin
                            state_next = pb_reg ? S_FIND_B : S_RESOLVE;
                        end
                    endcase
                end
            end
            S_FIND_B:
            begin
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (f_done)
                begin
                    rb_next    = f_root;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                rank_raddr = ra_reg;
                if (!pa_reg || !pb_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ufe_pkg::ST_MISSING;
                    root_next   = pa_reg ? ufe_pkg::elem_t'(ra_reg) : '0;
                    same_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (req_reg == ufe_pkg::REQ_UNION && ra_reg != rb_reg)
                begin
                    state_next = S_RANK_A;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ufe_pkg::ST_DONE;
                    root_next   = ufe_pkg::elem_t'(ra_reg);
                    same_next   = (ra_reg == rb_reg);
                    state_next  = S_IDLE;
                end
            end
            S_RANK_A:
            begin
                rank_a_next = rank_rdata;
                rank_raddr  = rb_reg;
                state_next  = S_RANK_B;
            end
            S_RANK_B:
            begin
                done_next   = 1'b1;
                status_next = ufe_pkg::ST_DONE;
                same_next   = 1'b1;
                state_next  = S_IDLE;
                seq_par_we  = 1'b1;
                if (rank_a_reg > rank_rdata)
                begin
                    // hang the lower-ranked root b under a
                    seq_par_waddr = rb_reg;
                    seq_par_wdata = ra_reg;
                    root_next     = ufe_pkg::elem_t'(ra_reg);
                end
                else
                begin
                    seq_par_waddr = ra_reg;
                    seq_par_wdata = rb_reg;
                    root_next     = ufe_pkg::elem_t'(rb_reg);
                    // grow the rank only on a tie, and saturate
                    if (rank_a_reg == rank_rdata && rank_rdata < ufe_pkg::RANK_MAX)
                    begin
                        rank_we    = 1'b1;
                        rank_waddr = rb_reg;
                        rank_wdata = rank_rdata + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        a_in_reg   <= a_in_next;
        b_in_reg   <= b_in_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rank_a_reg <= rank_a_next;
        status_reg <= status_next;
        root_reg   <= root_next;
        same_reg   <= same_next;
    end

    ufe_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_present (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (pres_raddr),
        .rdata (pres_rdata)
    );

    ufe_ram #(
        .WIDTH (ufe_pkg::RANK_W),
        .DEPTH (DEPTH)
    ) u_rank (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    ufe_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    ufe_find #(
        .NUM_ELEMENTS (NUM_ELEMENTS),
        .AW           (AW)
    ) u_find (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (f_start),
        .node      (f_node),
        .par_rdata (par_rdata),
        .par_raddr (par_raddr),
        .par_we    (f_we),
        .par_waddr (f_waddr),
        .par_wdata (f_wdata),
        .done      (f_done),
        .root      (f_root)
    );

    // A result word only follows a request that was in flight.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a request in flight");

    // The find unit reports only while the sequencer waits for it.
    a_find_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        f_done |-> (state_reg == S_WAIT_A || state_reg == S_WAIT_B))
        else $error("find unit finished outside a wait state");

    // Sequencer and find unit never write the parent table together.
    a_parent_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(f_we && seq_par_we))
        else $error("parent table written by two sources");

    // No table other than the present map is written, and no result is made, during the sweep.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!par_we && !rank_we && !done_next))
        else $error("table write or result during the reset sweep");

    // A missing element never reports a shared set.
    a_missing_not_same: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ufe_pkg::ST_MISSING) |-> !same_flag)
        else $error("same_flag set on a missing element");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for union_find_engine_core: make, union, query and find requests.
// Depends on ufe_pkg for request and status codes; an internal disjoint-set model predicts
// every result word.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;  // far above the slowest legal run
    localparam int unsigned TAIL_CYCLES = 64;      // waits for stray words after the drain

    typedef struct packed {
        ufe_pkg::status_t st;
        ufe_pkg::elem_t   root;
        logic             same;
    } uf_result_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [1:0] req_type;
    logic [9:0] elem_a;
    logic [9:0] elem_b;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [9:0] root_a;
    logic       same_flag;

    // Predicted forest: parent links, ranks and the present map.
    ufe_pkg::elem_t link_of [ufe_pkg::ELEM_SPAN];
    ufe_pkg::rank_t rank_of [ufe_pkg::ELEM_SPAN];
    bit             slot_live [ufe_pkg::ELEM_SPAN];
    ufe_pkg::elem_t live_slots [$];  // every slot made so far, for picking targets

    uf_result_t  expected_results [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    union_find_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .root_a    (root_a),
        .same_flag (same_flag)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Bound the run; a lost result word also ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Walk to the root, then point every node on the walked path straight at it.
    function automatic ufe_pkg::elem_t chase_root(ufe_pkg::elem_t e);
        ufe_pkg::elem_t top;
        ufe_pkg::elem_t walk;
        ufe_pkg::elem_t nxt;
        int unsigned    hops;
        int unsigned    k;
        top  = e;
        hops = 0;
        while (hops < ufe_pkg::ELEM_SPAN && link_of[top] != top)
        begin
            top = link_of[top];
            hops++;
        end
        walk = e;
        k    = 0;
        while (k < hops && walk != top)
        begin
            nxt           = link_of[walk];
            link_of[walk] = top;
            walk          = nxt;
            k++;
        end
        return top;
    endfunction

    // Apply one request to the predicted forest and return the word it must produce.
    function automatic uf_result_t dsu_predict(ufe_pkg::req_t rq, ufe_pkg::elem_t a,
                                               ufe_pkg::elem_t b);
        uf_result_t     r;
        ufe_pkg::elem_t ra;
        ufe_pkg::elem_t rb;
        r = '{st: ufe_pkg::ST_DONE, root: '0, same: 1'b0};
        case (rq)
            ufe_pkg::REQ_MAKE:
            begin
                if (slot_live[a])
                begin
                    r.st   = ufe_pkg::ST_EXISTS;
                    r.root = chase_root(a);
                end
                else
                begin
                    link_of[a]   = a;
                    rank_of[a]   = '0;
                    slot_live[a] = 1'b1;
                    live_slots.push_back(a);
                    r.root = a;
                end
            end
            ufe_pkg::REQ_FIND:
            begin
                if (slot_live[a])
                    r.root = chase_root(a);
                else
                    r.st = ufe_pkg::ST_MISSING;
            end
            default:
            begin
                // Order matters: a is compressed before b.
                ra = slot_live[a] ? chase_root(a) : ufe_pkg::elem_t'(0);
                rb = slot_live[b] ? chase_root(b) : ufe_pkg::elem_t'(0);
                if (!slot_live[a] || !slot_live[b])
                begin
                    r.st   = ufe_pkg::ST_MISSING;
                    r.root = ra;
                end
                else
                begin
                    if (rq == ufe_pkg::REQ_UNION && ra != rb)
                    begin
                        // Hang the lower-rank root; grow rank only on a tie.
                        if (rank_of[ra] > rank_of[rb])
                            link_of[rb] = ra;
                        else
                        begin
                            if (rank_of[ra] == rank_of[rb] && rank_of[rb] < ufe_pkg::RANK_MAX)
                                rank_of[rb] = rank_of[rb] + 1'b1;
                            link_of[ra] = rb;
                            ra = rb;
                        end
                        rb = ra;
                    end
                    r.root = ra;
                    r.same = (ra == rb);
                end
            end
        endcase
        return r;
    endfunction

    // Drive one request word at the falling edge and hold it until the engine takes it.
    // start stays high afterwards; pause_sender or the next word decides what follows.
    task automatic issue_request(ufe_pkg::req_t rq, ufe_pkg::elem_t a, ufe_pkg::elem_t b);
        @(negedge clk);
        start    <= 1'b1;
        req_type <= rq;
        elem_a   <= a;
        elem_b   <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_results.push_back(dsu_predict(rq, a, b));
    endtask

    // Drop start and scramble the idle inputs for a gap of length n (n >= 1).
    task automatic pause_sender(int unsigned n);
        @(negedge clk);
        start    <= 1'b0;
        req_type <= 2'($urandom);
        elem_a   <= 10'($urandom);
        elem_b   <= 10'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Mostly short gaps, now and then a long one; zero keeps words back to back.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic idle_gap();
        int unsigned n;
        n = gap_len();
        if (n != 0)
            pause_sender(n);
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic hold_until_drained();
        pause_sender(1);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic ufe_pkg::elem_t pick_slot(int unsigned span_hi);
        if (live_slots.size() != 0 && $urandom_range(0, 99) < 75)
            return live_slots[$urandom_range(0, live_slots.size() - 1)];
        return ufe_pkg::elem_t'($urandom_range(0, span_hi));
    endfunction

    // Compare every result word with the oldest prediction.
    always @(posedge clk)
    begin
        uf_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing pending: status %0d root_a %0d same_flag %0d",
                       status, root_a, same_flag);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    fail_count++;
                end
                if (root_a !== want.root)
                begin
                    $error("root_a: expected %0d, actual %0d", want.root, root_a);
                    fail_count++;
                end
                if (same_flag !== want.same)
                begin
                    $error("same_flag: expected %0d, actual %0d", want.same, same_flag);
                    fail_count++;
                end
            end
        end
    end

    // Corner cases: empty table, extreme slots, every status, both rank branches,
    // self-union, repeat union, compression of a two-link path.
    task automatic test_directed_cases();
        issue_request(ufe_pkg::REQ_FIND,  10'd5,    10'd0);     idle_gap();  // empty table
        issue_request(ufe_pkg::REQ_QUERY, 10'd5,    10'd6);     idle_gap();  // both missing
        issue_request(ufe_pkg::REQ_MAKE,  10'd0,    10'd1023);  idle_gap();
        issue_request(ufe_pkg::REQ_MAKE,  10'd1023, 10'd0);     idle_gap();
        issue_request(ufe_pkg::REQ_MAKE,  10'd0,    10'd0);     idle_gap();  // present
        issue_request(ufe_pkg::REQ_FIND,  10'd1023, 10'd0);     idle_gap();
        issue_request(ufe_pkg::REQ_UNION, 10'd0,    10'd1023);  idle_gap();  // equal ranks
        issue_request(ufe_pkg::REQ_QUERY, 10'd0,    10'd1023);  idle_gap();
        issue_request(ufe_pkg::REQ_UNION, 10'd0,    10'd0);     idle_gap();  // with itself
        issue_request(ufe_pkg::REQ_UNION, 10'd1023, 10'd0);     idle_gap();  // joined
        issue_request(ufe_pkg::REQ_UNION, 10'd0,    10'd700);   idle_gap();  // b missing
        issue_request(ufe_pkg::REQ_QUERY, 10'd700,  10'd0);     idle_gap();  // a missing
        issue_request(ufe_pkg::REQ_MAKE,  10'h2AA,  10'h155);   idle_gap();
        issue_request(ufe_pkg::REQ_MAKE,  10'h155,  10'h2AA);   idle_gap();
        issue_request(ufe_pkg::REQ_UNION, 10'h2AA,  10'h155);   idle_gap();
        issue_request(ufe_pkg::REQ_QUERY, 10'h2AA,  10'd0);     idle_gap();  // different sets
        issue_request(ufe_pkg::REQ_UNION, 10'h155,  10'd0);     idle_gap();  // tie at rank one
        issue_request(ufe_pkg::REQ_MAKE,  10'd512,  10'd0);     idle_gap();
        issue_request(ufe_pkg::REQ_UNION, 10'd1023, 10'd512);   idle_gap();  // higher rank a
        issue_request(ufe_pkg::REQ_MAKE,  10'd513,  10'd0);     idle_gap();
        issue_request(ufe_pkg::REQ_UNION, 10'd513,  10'd0);     idle_gap();  // lower rank a
        issue_request(ufe_pkg::REQ_FIND,  10'h2AA,  10'd0);     idle_gap();  // two-link path
        issue_request(ufe_pkg::REQ_QUERY, 10'h2AA,  10'd513);   idle_gap();
        issue_request(ufe_pkg::REQ_MAKE,  10'h2AA,  10'd0);     idle_gap();  // non-root
        issue_request(ufe_pkg::REQ_QUERY, 10'd1023, 10'd1023);  idle_gap();
    endtask

    // Random traffic that mostly targets made slots so that sets grow and merge.
    // Every 64 words, the last 16 go back to back.
    task automatic run_random_mix(int unsigned n_items, int unsigned span_hi);
        ufe_pkg::req_t  rq;
        ufe_pkg::elem_t a;
        ufe_pkg::elem_t b;
        int unsigned    roll;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (live_slots.size() < 8 || roll < 25)
                rq = ufe_pkg::REQ_MAKE;
            else if (roll < 55)
                rq = ufe_pkg::REQ_UNION;
            else if (roll < 80)
                rq = ufe_pkg::REQ_QUERY;
            else
                rq = ufe_pkg::REQ_FIND;
            a = (rq == ufe_pkg::REQ_MAKE) ? ufe_pkg::elem_t'($urandom_range(0, span_hi))
                                          : pick_slot(span_hi);
            b = pick_slot(span_hi);
            issue_request(rq, a, b);
            if (i % 64 < 48)
                idle_gap();
        end
    endtask

    // Dense pool: few slots, many unions, deep trees.
    task automatic test_random_small_pool();
        run_random_mix(300, 63);
    endtask

    // Whole index range: every bit of both slot fields, many missing slots.
    task automatic test_random_wide();
        run_random_mix(300, 1023);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = ufe_pkg::REQ_MAKE;
        elem_a   = '0;
        elem_b   = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // The present-map sweep after reset shows up as busy; the first word waits it out.
        test_directed_cases();
        hold_until_drained();
        test_random_small_pool();
        hold_until_drained();
        test_random_wide();
        hold_until_drained();

        // Catch any stray word after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
